>>> rtl/core/lefe_pkg.sv
// ----------------------------------------------------------------------------
// lefe_pkg
// shared types, codes and constants of the led effect frame engine
// ----------------------------------------------------------------------------
package lefe_pkg;

   // default strip length
   localparam int PIXEL_COUNT_DEF = 16;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EFFECT_KEY   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_KEY    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATUS_SHOW  = 2'd3;

   // event codes
   localparam logic [2:0] CMD_TICK     = 3'd0;
   localparam logic [2:0] CMD_KEY      = 3'd1;
   localparam logic [2:0] CMD_LAYER    = 3'd2;
   localparam logic [2:0] CMD_BATTERY  = 3'd3;
   localparam logic [2:0] CMD_ACTIVITY = 3'd4;

   // effect modes
   localparam logic [1:0] EFFECT_PLAIN  = 2'd0;
   localparam logic [1:0] EFFECT_COLUMN = 2'd1;
   localparam logic [1:0] EFFECT_ROW    = 2'd2;
   localparam logic [1:0] EFFECT_DIAG   = 2'd3;

   // reset values
   localparam logic [6:0] BRIGHTNESS_RST  = 7'd30;
   localparam logic [7:0] EFFECT_KEY_RST  = 8'h6A;
   localparam logic [7:0] SPEED_KEY_RST   = 8'h6B;
   localparam logic [6:0] STATUS_SHOW_RST = 7'd66;
   localparam logic [1:0] EFFECT_RST      = EFFECT_ROW;
   localparam logic [1:0] SPEED_RST       = 2'd1;
   localparam logic [6:0] CHARGE_RST      = 7'd100;

   // animation constants
   localparam int         HUE_SECTOR_SPAN = 43;
   localparam logic [7:0] COL_STEP        = 8'd30;
   localparam logic [7:0] ROW_STEP        = 8'd25;
   localparam logic [7:0] DIAG_STEP       = 8'd20;
   localparam logic [4:0] BLINK_PERIOD    = 5'd30;
   localparam logic [4:0] BLINK_ON        = 5'd15;
   localparam logic [7:0] LAYER_MAGENTA_B = 8'hA0;
   localparam logic [7:0] LAYER_AMBER_G   = 8'hC0;

   // divide by one hundred as multiply and shift, exact below 43690
   localparam int          PROD_W       = 15;
   localparam int          DIV100_SHIFT = 19;
   localparam int          QPROD_W      = 28;
   localparam logic [12:0] DIV100_MUL   = 13'd5243;

   typedef enum logic {
      ST_IDLE,
      ST_FRAME
   } lefe_state_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] keycode;
      logic       key_pressed;
      logic [7:0] layer_number;
      logic [6:0] battery_percent;
      logic       active_flag;
   } lefe_req_type;

   typedef struct packed {
      logic [3:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } lefe_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic issue;
   } lefe_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic tick_req;
      logic advance;
      logic at_last;
   } lefe_status_type;

   function automatic logic [2:0] hue_sector(input logic [7:0] h);
      logic [2:0] s;
      if (h < 8'(HUE_SECTOR_SPAN))          s = 3'd0;
      else if (h < 8'(2 * HUE_SECTOR_SPAN)) s = 3'd1;
      else if (h < 8'(3 * HUE_SECTOR_SPAN)) s = 3'd2;
      else if (h < 8'(4 * HUE_SECTOR_SPAN)) s = 3'd3;
      else if (h < 8'(5 * HUE_SECTOR_SPAN)) s = 3'd4;
      else                                  s = 3'd5;
      return s;
   endfunction

   function automatic logic [7:0] sector_start(input logic [2:0] s);
      logic [7:0] b;
      case (s)
         3'd0: b = 8'd0;
         3'd1: b = 8'(HUE_SECTOR_SPAN);
         3'd2: b = 8'(2 * HUE_SECTOR_SPAN);
         3'd3: b = 8'(3 * HUE_SECTOR_SPAN);
         3'd4: b = 8'(4 * HUE_SECTOR_SPAN);
         default: b = 8'(5 * HUE_SECTOR_SPAN);
      endcase
      return b;
   endfunction

   // (255 * x) >> 8
   function automatic logic [7:0] mul255_hi(input logic [7:0] x);
      logic [15:0] m;
      m = {x, 8'h00} - {8'h00, x};
      return m[15:8];
   endfunction

endpackage

>>> rtl/core/lefe_ctrl.sv
// ----------------------------------------------------------------------------
// lefe_ctrl
// sequencer: takes items, walks the pixels of a frame tick
// ----------------------------------------------------------------------------
module lefe_ctrl
   import lefe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  lefe_status_type status,
   output lefe_cmd_type    cmd
);

   lefe_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.tick_req) state_in = ST_FRAME;
         end
         ST_FRAME: begin
            if (status.advance && status.at_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      cmd.accept = 1'b0;
      cmd.issue  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_FRAME: begin
            cmd.issue = status.advance;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> rtl/core/lefe_datapath.sv
// ----------------------------------------------------------------------------
// lefe_datapath
// effect state, config registers and the pixel color pipeline
// ----------------------------------------------------------------------------
module lefe_datapath
   import lefe_pkg::*;
#(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lefe_req_type           req_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  lefe_cmd_type           cmd,
   output lefe_status_type        status,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output lefe_rsp_type           rsp_data
);

   localparam int               IDX_W    = $clog2(PIXEL_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

   typedef struct packed {
      logic [3:0] pixel_index;
      logic       last_pixel;
      logic       use_hue;
      logic [7:0] fix_r;
      logic [7:0] fix_g;
      logic [7:0] fix_b;
   } tag_type;

   // config registers
   logic [6:0] bright_ff, bright_in;
   logic [7:0] effect_key_ff, effect_key_in;
   logic [7:0] speed_key_ff, speed_key_in;
   logic [6:0] show_ff, show_in;

   // effect state
   logic [1:0]  effect_ff, effect_in;
   logic [1:0]  speed_ff, speed_in;
   logic        awake_ff, awake_in;
   logic [7:0]  layer_ff, layer_in;
   logic [6:0]  charge_ff, charge_in;
   logic [6:0]  countdown_ff, countdown_in;
   logic [31:0] frame_ff, frame_in;
   logic [4:0]  phase_ff, phase_in;

   // pixel walk
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]       col_ff, col_in;
   logic [IDX_W-1:0] row_ff, row_in;

   logic adv, at_last, frame_end, low_batt, layer_on;

   assign adv       = !rsp_valid || !rsp_stall;
   assign at_last   = (idx_ff == LAST_IDX);
   assign frame_end = cmd.issue && at_last;
   assign low_batt  = charge_ff inside {[7'd1:7'd9]};
   assign layer_on  = !low_batt && (countdown_ff != 7'd0);

   assign status.tick_req = (req_data.cmd == CMD_TICK);
   assign status.advance  = adv;
   assign status.at_last  = at_last;

   always_comb begin
      bright_in     = bright_ff;
      effect_key_in = effect_key_ff;
      speed_key_in  = speed_key_ff;
      show_in       = show_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_BRIGHTNESS:  bright_in     = csr_wdata[6:0];
            CSR_EFFECT_KEY:  effect_key_in = csr_wdata;
            CSR_SPEED_KEY:   speed_key_in  = csr_wdata;
            CSR_STATUS_SHOW: show_in       = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      effect_in    = effect_ff;
      speed_in     = speed_ff;
      awake_in     = awake_ff;
      layer_in     = layer_ff;
      charge_in    = charge_ff;
      countdown_in = countdown_ff;
      frame_in     = frame_ff;
      phase_in     = phase_ff;
      if (cmd.accept) begin
         case (req_data.cmd)
            CMD_KEY: begin
               if (req_data.key_pressed) begin
                  if (req_data.keycode == effect_key_ff) effect_in = effect_ff + 2'd1;
                  if (req_data.keycode == speed_key_ff)
                     speed_in = (speed_ff >= 2'd3) ? 2'd1 : speed_ff + 2'd1;
               end
            end
            CMD_LAYER: begin
               layer_in     = req_data.layer_number;
               countdown_in = show_ff;
            end
            CMD_BATTERY: charge_in = req_data.battery_percent;
            CMD_ACTIVITY: begin
               awake_in = req_data.active_flag;
               if (req_data.active_flag) countdown_in = show_ff;
            end
            default: ;
         endcase
      end
      if (frame_end && awake_ff) begin
         frame_in = frame_ff + 32'd1;
         // blink phase follows the frame count mod 30, restarting when it wraps
         phase_in = (phase_ff == BLINK_PERIOD - 5'd1 || frame_ff == '1) ?
                    5'd0 : phase_ff + 5'd1;
         if (layer_on) countdown_in = countdown_ff - 7'd1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.accept || frame_end) begin
         idx_in = '0;
         col_in = 2'd0;
         row_in = '0;
      end else if (cmd.issue) begin
         idx_in = idx_ff + IDX_W'(1);
         if (col_ff == 2'd2) begin
            col_in = 2'd0;
            row_in = row_ff + IDX_W'(1);
         end else begin
            col_in = col_ff + 2'd1;
         end
      end
   end

   // stage 1: hue and the fixed color of the status light
   logic [7:0] base_hue, col8, row8;
   logic [7:0] s1_hue_in, s1_hue_ff;
   tag_type    s1_tag_in, s1_tag_ff;

   always_comb begin
      base_hue = frame_ff[7:0] * {6'd0, speed_ff};
      col8     = {6'd0, col_ff};
      row8     = 8'(row_ff);
      case (effect_ff)
         EFFECT_PLAIN:  s1_hue_in = base_hue;
         EFFECT_COLUMN: s1_hue_in = base_hue - col8 * COL_STEP;
         EFFECT_ROW:    s1_hue_in = base_hue - row8 * ROW_STEP;
         EFFECT_DIAG:   s1_hue_in = base_hue - (col8 + row8) * DIAG_STEP;
         default:       s1_hue_in = base_hue;
      endcase
      s1_tag_in.pixel_index = 4'(idx_ff);
      s1_tag_in.last_pixel  = at_last;
      s1_tag_in.use_hue     = awake_ff && !at_last;
      s1_tag_in.fix_r       = 8'h00;
      s1_tag_in.fix_g       = 8'h00;
      s1_tag_in.fix_b       = 8'h00;
      if (awake_ff && at_last) begin
         if (low_batt) begin
            if (phase_ff < BLINK_ON) s1_tag_in.fix_r = 8'hFF;
         end else if (layer_on) begin
            case (layer_ff)
               8'd0: begin
                  s1_tag_in.fix_r = 8'hFF;
                  s1_tag_in.fix_b = LAYER_MAGENTA_B;
               end
               8'd1: begin
                  s1_tag_in.fix_r = 8'hFF;
                  s1_tag_in.fix_g = LAYER_AMBER_G;
               end
               8'd2: s1_tag_in.fix_g = 8'hFF;
               default: begin
                  s1_tag_in.fix_r = 8'hFF;
                  s1_tag_in.fix_g = 8'hFF;
                  s1_tag_in.fix_b = 8'hFF;
               end
            endcase
         end
      end
   end

   // stage 2: sector and position inside it
   logic [2:0] s2_sector_in, s2_sector_ff;
   logic [7:0] s2_frac_in, s2_frac_ff;
   logic [7:0] s2_rem;
   tag_type    s2_tag_ff;

   always_comb begin
      s2_sector_in = hue_sector(s1_hue_ff);
      s2_rem       = s1_hue_ff - sector_start(s2_sector_in);
      s2_frac_in   = s2_rem * 8'd6;
   end

   // stage 3: first scaling of falling and rising ramps
   logic [2:0] s3_sector_ff;
   logic [7:0] s3_t1_in, s3_t1_ff, s3_t2_in, s3_t2_ff;
   tag_type    s3_tag_ff;

   assign s3_t1_in = mul255_hi(s2_frac_ff);
   assign s3_t2_in = mul255_hi(8'hFF - s2_frac_ff);

   // stage 4: ramps and channel select
   logic [7:0] fall, rise;
   logic [7:0] s4_r_in, s4_g_in, s4_b_in, s4_r_ff, s4_g_ff, s4_b_ff;
   tag_type    s4_tag_ff;

   always_comb begin
      fall = mul255_hi(8'hFF - s3_t1_ff);
      rise = mul255_hi(8'hFF - s3_t2_ff);
      case (s3_sector_ff)
         3'd0: begin s4_r_in = 8'hFF; s4_g_in = rise;  s4_b_in = 8'h00; end
         3'd1: begin s4_r_in = fall;  s4_g_in = 8'hFF; s4_b_in = 8'h00; end
         3'd2: begin s4_r_in = 8'h00; s4_g_in = 8'hFF; s4_b_in = rise;  end
         3'd3: begin s4_r_in = 8'h00; s4_g_in = fall;  s4_b_in = 8'hFF; end
         3'd4: begin s4_r_in = rise;  s4_g_in = 8'h00; s4_b_in = 8'hFF; end
         default: begin s4_r_in = 8'hFF; s4_g_in = 8'h00; s4_b_in = fall; end
      endcase
      if (!s3_tag_ff.use_hue) begin
         s4_r_in = s3_tag_ff.fix_r;
         s4_g_in = s3_tag_ff.fix_g;
         s4_b_in = s3_tag_ff.fix_b;
      end
   end

   // stage 5: channel times brightness
   logic [PROD_W-1:0] s5_r_in, s5_g_in, s5_b_in, s5_r_ff, s5_g_ff, s5_b_ff;
   tag_type           s5_tag_ff;

   assign s5_r_in = PROD_W'(s4_r_ff) * PROD_W'(bright_ff);
   assign s5_g_in = PROD_W'(s4_g_ff) * PROD_W'(bright_ff);
   assign s5_b_in = PROD_W'(s4_b_ff) * PROD_W'(bright_ff);

   // stage 6: divide by one hundred
   logic [QPROD_W-1:0]      qr, qg, qb;
   logic [QPROD_W-DIV100_SHIFT-1:0] s6_r_in, s6_g_in, s6_b_in, s6_r_ff, s6_g_ff, s6_b_ff;
   tag_type                 s6_tag_ff;

   always_comb begin
      qr      = QPROD_W'(s5_r_ff) * QPROD_W'(DIV100_MUL);
      qg      = QPROD_W'(s5_g_ff) * QPROD_W'(DIV100_MUL);
      qb      = QPROD_W'(s5_b_ff) * QPROD_W'(DIV100_MUL);
      s6_r_in = qr[QPROD_W-1:DIV100_SHIFT];
      s6_g_in = qg[QPROD_W-1:DIV100_SHIFT];
      s6_b_in = qb[QPROD_W-1:DIV100_SHIFT];
   end

   // output register with saturation
   logic         s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic         s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   lefe_rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_valid_in = adv ? s6_valid_ff : rsp_valid_ff;
      rsp_data_in.pixel_index = s6_tag_ff.pixel_index;
      rsp_data_in.last_pixel  = s6_tag_ff.last_pixel;
      rsp_data_in.red   = (s6_r_ff > 9'd255) ? 8'hFF : s6_r_ff[7:0];
      rsp_data_in.green = (s6_g_ff > 9'd255) ? 8'hFF : s6_g_ff[7:0];
      rsp_data_in.blue  = (s6_b_ff > 9'd255) ? 8'hFF : s6_b_ff[7:0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff     <= BRIGHTNESS_RST;
         effect_key_ff <= EFFECT_KEY_RST;
         speed_key_ff  <= SPEED_KEY_RST;
         show_ff       <= STATUS_SHOW_RST;
         effect_ff     <= EFFECT_RST;
         speed_ff      <= SPEED_RST;
         awake_ff      <= 1'b1;
         layer_ff      <= 8'd0;
         charge_ff     <= CHARGE_RST;
         countdown_ff  <= STATUS_SHOW_RST;
         frame_ff      <= 32'd0;
         phase_ff      <= 5'd0;
         idx_ff        <= '0;
         col_ff        <= 2'd0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         s5_valid_ff   <= 1'b0;
         s6_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bright_ff     <= bright_in;
         effect_key_ff <= effect_key_in;
         speed_key_ff  <= speed_key_in;
         show_ff       <= show_in;
         effect_ff     <= effect_in;
         speed_ff      <= speed_in;
         awake_ff      <= awake_in;
         layer_ff      <= layer_in;
         charge_ff     <= charge_in;
         countdown_ff  <= countdown_in;
         frame_ff      <= frame_in;
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (adv) begin
            s1_valid_ff <= cmd.issue;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
            s5_valid_ff <= s4_valid_ff;
            s6_valid_ff <= s5_valid_ff;
         end
      end
   end

   // payload stages, no reset
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_hue_ff    <= s1_hue_in;
         s1_tag_ff    <= s1_tag_in;
         s2_sector_ff <= s2_sector_in;
         s2_frac_ff   <= s2_frac_in;
         s2_tag_ff    <= s1_tag_ff;
         s3_sector_ff <= s2_sector_ff;
         s3_t1_ff     <= s3_t1_in;
         s3_t2_ff     <= s3_t2_in;
         s3_tag_ff    <= s2_tag_ff;
         s4_r_ff      <= s4_r_in;
         s4_g_ff      <= s4_g_in;
         s4_b_ff      <= s4_b_in;
         s4_tag_ff    <= s3_tag_ff;
         s5_r_ff      <= s5_r_in;
         s5_g_ff      <= s5_g_in;
         s5_b_ff      <= s5_b_in;
         s5_tag_ff    <= s4_tag_ff;
         s6_r_ff      <= s6_r_in;
         s6_g_ff      <= s6_g_in;
         s6_b_ff      <= s6_b_in;
         s6_tag_ff    <= s5_tag_ff;
         rsp_data_ff  <= rsp_data_in;
      end
   end

endmodule

>>> rtl/core/led_effect_frame_engine.sv
// ----------------------------------------------------------------------------
// led_effect_frame_engine
// event driven rainbow animation engine for a strip of color leds
// ----------------------------------------------------------------------------
// timing: a non-tick item is taken in the cycle it is presented; after a frame tick the first
//   pixel is issued, then passes through the stage registers into the output register
// throughput: one pixel per cycle while the output does not stall; a frame tick holds the
//   input while it is taken and while its PIXEL_COUNT pixels are issued, longer
//   while the output stalls; the next item is taken the cycle after that
// reset: synchronous, puts config and effect state at their defaults at once
// ----------------------------------------------------------------------------
module led_effect_frame_engine
   import lefe_pkg::*;
#(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // event items
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lefe_req_type           req_data,
   // pixel items
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lefe_rsp_type           rsp_data,
   // register writes
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // command and status between sequencer and datapath
   lefe_cmd_type    cmd;
   lefe_status_type status;

   // sequencer: idle takes an item, frame walks the pixels
   lefe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // state, config, hue to rgb pipeline, brightness scaling, output register
   lefe_datapath #(
      .PIXEL_COUNT (PIXEL_COUNT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule

>>> tb/tb_led_effect_frame_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_effect_frame_engine
// self-checking bench for the led effect frame engine: a scoreboard class
// keeps its own copy of the animation state and registers, predicts the
// sixteen pixels of every accepted frame tick and checks each pixel item in
// order; directed events come first, then three random phases under
// different register settings and idling patterns
// ----------------------------------------------------------------------------
module tb_led_effect_frame_engine;
   import lefe_pkg::*;

   localparam int PIXELS      = PIXEL_COUNT_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_GAP  = 24;          // more than the tick-to-pixel latency
   localparam int LONG_HOLD   = 400;         // receiver hold-off in cycles
   localparam int PHASE_ITEMS = 58;
   localparam int REPORT_MAX  = 10;

   // command codes the block ignores
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   // predicts pixel items from events and holds them until they show up
   class strip_scoreboard;
      // register copies
      logic [6:0]   brightness;
      logic [7:0]   effect_key;
      logic [7:0]   speed_key;
      logic [6:0]   show_frames;
      // animation state
      logic [31:0]  frame_count;
      logic [1:0]   effect_mode;
      logic [1:0]   speed;
      logic         awake;
      logic [7:0]   layer;
      logic [6:0]   charge;
      logic [6:0]   countdown;
      lefe_rsp_type expected_pixels[$];
      int           errors;

      function new();
         brightness  = BRIGHTNESS_RST;
         effect_key  = EFFECT_KEY_RST;
         speed_key   = SPEED_KEY_RST;
         show_frames = STATUS_SHOW_RST;
         frame_count = '0;
         effect_mode = EFFECT_RST;
         speed       = SPEED_RST;
         awake       = 1'b1;
         layer       = '0;
         charge      = CHARGE_RST;
         countdown   = STATUS_SHOW_RST;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BRIGHTNESS:  brightness  = data[6:0];
            CSR_EFFECT_KEY:  effect_key  = data;
            CSR_SPEED_KEY:   speed_key   = data;
            CSR_STATUS_SHOW: show_frames = data[6:0];
            default: ;
         endcase
      endfunction

      // full saturation and value rainbow, six sectors of 43 hue steps, the last one 41
      function void hue_to_rgb(input logic [7:0] h, output int r, output int g,
                               output int b);
         int sector, frac, fall, rise;
         sector = h / HUE_SECTOR_SPAN;
         frac   = (h - sector * HUE_SECTOR_SPAN) * 6;
         fall   = (255 * (255 - ((255 * frac) >> 8))) >> 8;
         rise   = (255 * (255 - ((255 * (255 - frac)) >> 8))) >> 8;
         case (sector)
            0: begin r = 255;  g = rise; b = 0;    end
            1: begin r = fall; g = 255;  b = 0;    end
            2: begin r = 0;    g = 255;  b = rise; end
            3: begin r = 0;    g = fall; b = 255;  end
            4: begin r = rise; g = 0;    b = 255;  end
            default: begin r = 255; g = 0; b = fall; end
         endcase
      endfunction

      // brightness scale, saturating when brightness is over one hundred
      function logic [7:0] dim(int c);
         int v;
         v = (c * brightness) / 100;
         return (v > 255) ? 8'd255 : 8'(v);
      endfunction

      function void take_event(lefe_req_type ev);
         int           r, g, b, col, row;
         logic [31:0]  prod;
         logic [7:0]   hue;
         lefe_rsp_type px;
         case (ev.cmd)
            CMD_KEY: begin
               if (ev.key_pressed) begin
                  if (ev.keycode == effect_key) effect_mode = effect_mode + 2'd1;
                  if (ev.keycode == speed_key) speed = (speed >= 2'd3) ? 2'd1 : speed + 2'd1;
               end
            end
            CMD_LAYER: begin
               layer     = ev.layer_number;
               countdown = show_frames;
            end
            CMD_BATTERY: charge = ev.battery_percent;
            CMD_ACTIVITY: begin
               if (ev.active_flag) begin
                  awake     = 1'b1;
                  countdown = show_frames;
               end else begin
                  awake = 1'b0;
               end
            end
            CMD_TICK: begin
               for (int i = 0; i < PIXELS; i++) begin
                  r = 0;
                  g = 0;
                  b = 0;
                  if (awake && i != PIXELS - 1) begin
                     col  = i % 3;
                     row  = i / 3;
                     prod = frame_count * speed;
                     hue  = prod[7:0];
                     case (effect_mode)
                        EFFECT_COLUMN: hue = hue - 8'(col * COL_STEP);
                        EFFECT_ROW:    hue = hue - 8'(row * ROW_STEP);
                        EFFECT_DIAG:   hue = hue - 8'((col + row) * DIAG_STEP);
                        default: ;
                     endcase
                     hue_to_rgb(hue, r, g, b);
                  end else if (awake) begin
                     if (charge > 0 && charge < 10) begin
                        // low battery blink
                        if (frame_count % BLINK_PERIOD < BLINK_ON) r = 255;
                     end else if (countdown > 0) begin
                        case (layer)
                           8'd0: begin r = 255; b = LAYER_MAGENTA_B; end
                           8'd1: begin r = 255; g = LAYER_AMBER_G;   end
                           8'd2: g = 255;
                           default: begin r = 255; g = 255; b = 255; end
                        endcase
                        countdown = countdown - 7'd1;
                     end
                  end
                  px.pixel_index = 4'(i);
                  px.red         = dim(r);
                  px.green       = dim(g);
                  px.blue        = dim(b);
                  px.last_pixel  = (i == PIXELS - 1);
                  expected_pixels.push_back(px);
               end
               if (awake) frame_count = frame_count + 32'd1;
            end
            default: ;
         endcase
      endfunction

      function void check_pixel(lefe_rsp_type got);
         lefe_rsp_type want;
         if (expected_pixels.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("unexpected pixel: idx %0d rgb %02h %02h %02h last %0d",
                        got.pixel_index, got.red, got.green, got.blue, got.last_pixel);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.pixel_index != want.pixel_index || got.red != want.red ||
             got.green != want.green || got.blue != want.blue ||
             got.last_pixel != want.last_pixel) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("pixel mismatch: want idx %0d rgb %02h %02h %02h last %0d, %s",
                        want.pixel_index, want.red, want.green, want.blue,
                        want.last_pixel,
                        $sformatf("got idx %0d rgb %02h %02h %02h last %0d",
                                  got.pixel_index, got.red, got.green, got.blue,
                                  got.last_pixel));
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   lefe_req_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   lefe_rsp_type           rsp_data;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   strip_scoreboard sb = new();

   int send_idle_pct;     // chance in percent that the sender skips a cycle
   int recv_stall_pct;    // chance in percent that the receiver stalls a cycle
   int hold_left;         // long receiver hold-off, counted down by the receiver
   int cycle_count;

   led_effect_frame_engine u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
      end
   end

   // pixel checking and run limit
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) sb.check_pixel(rsp_data);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // present one item with random gaps ahead of it, return after acceptance;
   // entered and left at a falling edge
   task automatic send_event(input lefe_req_type ev);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_event(ev);
      @(negedge clock);
   endtask

   // random filler in the fields the command does not use
   function automatic lefe_req_type noisy_event(logic [2:0] cmd);
      lefe_req_type ev;
      ev     = lefe_req_type'(28'($urandom));
      ev.cmd = cmd;
      return ev;
   endfunction

   task automatic send_key(input logic [7:0] key, input logic pressed);
      lefe_req_type ev;
      ev             = noisy_event(CMD_KEY);
      ev.keycode     = key;
      ev.key_pressed = pressed;
      send_event(ev);
   endtask

   // tick, layer, battery, activity or a spare code with its one argument
   task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] arg);
      lefe_req_type ev;
      ev = noisy_event(cmd);
      case (cmd)
         CMD_LAYER:    ev.layer_number    = arg;
         CMD_BATTERY:  ev.battery_percent = arg[6:0];
         CMD_ACTIVITY: ev.active_flag     = arg[0];
         default: ;
      endcase
      send_event(ev);
   endtask

   // stop sending, let every pixel come out, then give the pipe time to empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_GAP) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   // all four registers back to back, only while the block is idle
   task automatic configure(input logic [6:0] bright, input logic [7:0] ekey,
                            input logic [7:0] skey, input logic [6:0] show);
      csr_write(CSR_BRIGHTNESS, {1'b0, bright});
      csr_write(CSR_EFFECT_KEY, ekey);
      csr_write(CSR_SPEED_KEY, skey);
      csr_write(CSR_STATUS_SHOW, {1'b0, show});
      csr_write_en <= 1'b0;
   endtask

   // mostly ticks and meaningful key presses, some noise and spare codes
   function automatic lefe_req_type random_event();
      lefe_req_type ev;
      int           pick;
      pick = $urandom_range(99);
      if (pick < 38) begin
         ev = noisy_event(CMD_TICK);
      end else if (pick < 58) begin
         ev = noisy_event(CMD_KEY);
         case ($urandom_range(9))
            0, 1, 2, 3, 4: ev.keycode = sb.effect_key;
            5, 6, 7:       ev.keycode = sb.speed_key;
            default: ;
         endcase
         ev.key_pressed = ($urandom_range(3) != 0);
      end else if (pick < 68) begin
         ev = noisy_event(CMD_LAYER);
         if ($urandom_range(1)) ev.layer_number = 8'($urandom_range(3));
      end else if (pick < 76) begin
         ev = noisy_event(CMD_BATTERY);
         case ($urandom_range(9))
            0, 1, 2, 3: ev.battery_percent = 7'($urandom_range(1, 9));
            4:          ev.battery_percent = 7'd0;
            default: ;
         endcase
      end else if (pick < 92) begin
         ev = noisy_event(CMD_ACTIVITY);
         ev.active_flag = ($urandom_range(3) != 0);
      end else begin
         ev = noisy_event(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)));
      end
      return ev;
   endfunction

   // releases and spare codes are ignored by the block and do not count
   task automatic run_random(input int n);
      lefe_req_type ev;
      int           counted;
      counted = 0;
      while (counted < n) begin
         ev = random_event();
         send_event(ev);
         if (ev.cmd <= CMD_ACTIVITY && !(ev.cmd == CMD_KEY && !ev.key_pressed))
            counted++;
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 0;
      cycle_count    = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed events under reset settings
      send_cmd(CMD_TICK, 8'd0);                  // layer 0 status color
      send_key(EFFECT_KEY_RST, 1'b0);            // release is ignored
      send_key(EFFECT_KEY_RST, 1'b1);            // row -> diagonal
      send_key(SPEED_KEY_RST, 1'b1);             // speed 2
      send_cmd(CMD_TICK, 8'd0);
      send_cmd(CMD_LAYER, 8'd1);
      send_cmd(CMD_TICK, 8'd0);
      send_cmd(CMD_LAYER, 8'd2);
      send_cmd(CMD_TICK, 8'd0);
      send_cmd(CMD_LAYER, 8'd255);               // any other layer is white
      send_cmd(CMD_TICK, 8'd0);
      send_cmd(CMD_BATTERY, 8'd5);               // low battery blink
      send_cmd(CMD_TICK, 8'd0);
      send_cmd(CMD_BATTERY, 8'd0);               // zero charge is not low
      send_cmd(CMD_TICK, 8'd0);
      send_cmd(CMD_BATTERY, 8'd127);             // above one hundred, stored as is
      send_cmd(CMD_ACTIVITY, 8'd0);              // asleep
      send_cmd(CMD_TICK, 8'd0);                  // all black, counters hold
      send_cmd(CMD_SPARE_LO, 8'd0);
      send_cmd(CMD_SPARE_HI, 8'd0);
      send_cmd(CMD_ACTIVITY, 8'd1);              // wake reloads the countdown
      send_key(SPEED_KEY_RST, 1'b1);             // speed 3
      send_key(SPEED_KEY_RST, 1'b1);             // speed wraps to 1
      send_key(EFFECT_KEY_RST, 1'b1);            // effect wraps to plain
      send_cmd(CMD_TICK, 8'd0);

      // receiver holds off while ticks keep coming, so the input backs up
      @(posedge clock);
      hold_left = LONG_HOLD;
      @(negedge clock);
      repeat (5) send_cmd(CMD_TICK, 8'd0);
      settle();

      // zero brightness blacks out every channel
      configure(7'd0, EFFECT_KEY_RST, SPEED_KEY_RST, STATUS_SHOW_RST);
      send_cmd(CMD_TICK, 8'd0);
      settle();

      // phase one: one keycode drives both counters, no status window
      configure(7'd100, 8'h55, 8'h55, 7'd0);
      send_idle_pct  = 38;
      recv_stall_pct = 79;
      run_random(PHASE_ITEMS);
      settle();

      // phase two: saturating brightness, extreme keycodes, longest status window
      configure(7'd127, 8'h00, 8'hFF, 7'd127);
      send_idle_pct  = 79;
      recv_stall_pct = 38;
      run_random(PHASE_ITEMS);
      settle();

      // phase three: odd brightness, short status window, no idling
      configure(7'd57, EFFECT_KEY_RST, SPEED_KEY_RST, 7'd5);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(PHASE_ITEMS);
      settle();

      if (sb.errors == 0 && sb.expected_pixels.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
